>>> rtl/ipv4sf_pkg.sv
// Package for the IPv4 descending sort filter: payload types, filter codes and helpers.
`timescale 1ns / 1ps

package ipv4sf_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int ADDR_W       = 32;
    localparam int OCTET_W      = 8;
    localparam int MODE_W       = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;

    // Filter modes
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIRST2 = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ANY    = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_FIRST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_SECOND = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              last;
    } t_in;

    typedef struct packed {
        logic [ADDR_W-1:0] sorted_address;
        logic              final_res;
        logic              found;
        logic              overflowed;
    } t_out;

    function automatic logic passes(
        input logic [ADDR_W-1:0]  a,
        input logic [MODE_W-1:0]  mode,
        input logic [OCTET_W-1:0] m1,
        input logic [OCTET_W-1:0] m2
    );
        logic res;
        res = 1'b1;
        unique case (mode)
            MODE_NONE:   res = 1'b1;
            MODE_FIRST:  res = (a[31:24] == m1);
            MODE_FIRST2: res = (a[31:24] == m1) && (a[23:16] == m2);
            MODE_ANY:    res = (a[31:24] == m1) || (a[23:16] == m1) ||
                               (a[15:8] == m1) || (a[7:0] == m1);
            default:     res = 1'b1;
        endcase
        return res;
    endfunction

endpackage

>>> rtl/ipv4sf_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module ipv4sf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

>>> rtl/ipv4_sort_descending_filter.sv
// Top level of the IPv4 descending sort filter.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (i_valid / o_stall, payload i_in): one IPv4 address per request.
//   Each address is insertion-sorted into a RAM kept in descending order. The
//   insert walks down from the fill count, one RAM entry per cycle (read, compare,
//   shift-write), moving each stored entry smaller than the address one place up.
//   An address into an empty store is written directly; one that arrives when the
//   store is full is dropped and flagged. On the request with last set, the store
//   is scanned from the largest entry: each entry is read from the RAM, then
//   checked against the filter, and each result waits until the receiver takes
//   it. One matching result is held back so the final one can carry final_res;
//   if none match, one not-found result is sent.
//   Output channel (o_valid / i_stall, payload o_out): the result register holds
//   while i_stall is high; the scan waits on it.
//   Configuration (i_cfg_valid / o_cfg_ready): always ready; write only while idle.
//   Reset (synchronous, i_rst_n low): empty store, flag clear, filter mode none.
//
module ipv4_sort_descending_filter #(
    parameter int CAPACITY = ipv4sf_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input requests
    input  logic                                i_valid,
    output logic                                o_stall,
    input  ipv4sf_pkg::t_in                     i_in,
    // results
    output logic                                o_valid,
    input  logic                                i_stall,
    output ipv4sf_pkg::t_out                    o_out,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ipv4sf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ipv4sf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = ipv4sf_pkg::ADDR_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_PUT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_OUT_MID,
        S_OUT_LAST
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic [AW-1:0] r_idx, n_idx;
    logic [DW-1:0] r_addr, n_addr;
    logic          r_last, n_last;
    logic [DW-1:0] r_pend, n_pend;
    logic          r_have, n_have;
    ipv4sf_pkg::t_out r_out, n_out;
    logic          r_out_valid, n_out_valid;

    logic [ipv4sf_pkg::MODE_W-1:0]  r_mode;
    logic [ipv4sf_pkg::OCTET_W-1:0] r_m1;
    logic [ipv4sf_pkg::OCTET_W-1:0] r_m2;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [DW-1:0] mem_rdata;

    logic          in_acc;
    logic          out_acc;
    logic          pass;
    logic          scan_end;
    logic [CW-1:0] cnt_m1;
    logic [AW-1:0] idx_m1;
    logic [AW-1:0] idx_m2;

    ipv4sf_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    assign in_acc   = i_valid && (r_state == S_IDLE);
    assign out_acc  = r_out_valid && !i_stall;
    assign cnt_m1   = r_count - 1'b1;
    assign idx_m1   = r_idx - 1'b1;
    assign idx_m2   = idx_m1 - 1'b1;
    assign scan_end = (CW'(r_idx) == cnt_m1);
    assign pass     = ipv4sf_pkg::passes(mem_rdata, r_mode, r_m1, r_m2);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_idx       = r_idx;
        n_addr      = r_addr;
        n_last      = r_last;
        n_pend      = r_pend;
        n_have      = r_have;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        mem_we      = 1'b0;
        mem_waddr   = r_idx;
        mem_wdata   = r_addr;
        mem_raddr   = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_addr = i_in.address;
                    n_last = i_in.last;
                    if (r_count == CW'(CAPACITY)) begin
                        // store full: drop and flag
                        n_ovf = 1'b1;
                        if (i_in.last) begin
                            n_idx   = '0;
                            n_state = S_SCAN_RD;
                        end
                    end else if (r_count == '0) begin
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        mem_wdata = i_in.address;
                        n_count   = CW'(1);
                        if (i_in.last) begin
                            n_idx   = '0;
                            n_state = S_SCAN_RD;
                        end
                    end else begin
                        mem_raddr = cnt_m1[AW-1:0];
                        n_idx     = r_count[AW-1:0];
                        n_state   = S_INS_CMP;
                    end
                end
            end

            S_INS_CMP: begin
                // mem_rdata holds entry r_idx-1
                mem_we = 1'b1;
                if (mem_rdata < r_addr) begin
                    mem_waddr = r_idx;
                    mem_wdata = mem_rdata;
                    n_idx     = idx_m1;
                    if (idx_m1 == '0) begin
                        n_state = S_INS_PUT;
                    end else begin
                        mem_raddr = idx_m2;
                    end
                end else begin
                    mem_waddr = r_idx;
                    mem_wdata = r_addr;
                    n_count   = r_count + 1'b1;
                    n_idx     = '0;
                    n_state   = r_last ? S_SCAN_RD : S_IDLE;
                end
            end

            S_INS_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = r_addr;
                n_count   = r_count + 1'b1;
                n_idx     = '0;
                n_state   = r_last ? S_SCAN_RD : S_IDLE;
            end

            S_SCAN_RD: begin
                mem_raddr = r_idx;
                n_state   = S_SCAN_CHK;
            end

            S_SCAN_CHK: begin
                if (pass && r_have) begin
                    n_out.sorted_address = r_pend;
                    n_out.final_res      = 1'b0;
                    n_out.found          = 1'b1;
                    n_out.overflowed     = r_ovf;
                    n_out_valid          = 1'b1;
                    n_pend               = mem_rdata;
                    n_state              = S_OUT_MID;
                end else begin
                    if (pass) begin
                        n_pend = mem_rdata;
                        n_have = 1'b1;
                    end
                    if (scan_end) begin
                        n_out.sorted_address = n_have ? n_pend : '0;
                        n_out.final_res      = 1'b1;
                        n_out.found          = n_have;
                        n_out.overflowed     = r_ovf;
                        n_out_valid          = 1'b1;
                        n_state              = S_OUT_LAST;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_SCAN_RD;
                    end
                end
            end

            S_OUT_MID: begin
                if (out_acc) begin
                    if (scan_end) begin
                        n_out.sorted_address = r_pend;
                        n_out.final_res      = 1'b1;
                        n_out.found          = 1'b1;
                        n_out.overflowed     = r_ovf;
                        n_out_valid          = 1'b1;
                        n_state              = S_OUT_LAST;
                    end else begin
                        n_out_valid = 1'b0;
                        n_idx       = r_idx + 1'b1;
                        n_state     = S_SCAN_RD;
                    end
                end
            end

            S_OUT_LAST: begin
                if (out_acc) begin
                    n_out_valid = 1'b0;
                    n_count     = '0;
                    n_ovf       = 1'b0;
                    n_have      = 1'b0;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_idx       <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= ipv4sf_pkg::MODE_NONE;
            r_m1        <= '0;
            r_m2        <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_idx       <= n_idx;
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    ipv4sf_pkg::REG_FILTER_MODE:  r_mode <= i_cfg_data[ipv4sf_pkg::MODE_W-1:0];
                    ipv4sf_pkg::REG_MATCH_FIRST:  r_m1   <= i_cfg_data;
                    ipv4sf_pkg::REG_MATCH_SECOND: r_m2   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_addr <= n_addr;
        r_last <= n_last;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("fill count above capacity");

    // A result is shown only in the output states.
    a_valid_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_OUT_MID || r_state == S_OUT_LAST))
        else $error("result valid outside output states");

    // Not-found results always close the run.
    a_notfound_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.found) |-> r_out.final_res)
        else $error("not-found result without final mark");

    // Taking the final result empties the store.
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT_LAST && out_acc) |=> (r_count == '0 && !r_ovf))
        else $error("store not cleared after final result");

endmodule
